/* rtl/core/segment_pair_intersection_xy_defines.svh */
// Assertion macros shared by the segment pair intersection RTL.
`ifndef SEGMENT_PAIR_INTERSECTION_XY_DEFINES_SVH
`define SEGMENT_PAIR_INTERSECTION_XY_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define SPI_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SPI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/spi_pkg.sv */
// Types and constants shared by the segment pair intersection modules.
`default_nettype none
package spi_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned DIFF_W  = 33;
    localparam int unsigned PROD_W  = 66;
    localparam int unsigned WIDE_W  = 68;
    localparam int unsigned NUM_W   = 67;
    localparam int unsigned DIR_W   = 34;
    localparam int unsigned SPLIT_W = 34;
    localparam int unsigned MUL_W   = NUM_W + DIR_W;
    localparam int unsigned QUOT_W  = 35;
    localparam int unsigned REM_W   = NUM_W + 1;
    localparam int unsigned SUM_W   = QUOT_W + 2;
    localparam int unsigned LANES   = 3;
    localparam int unsigned MID_DEPTH_DEF = 4;

    localparam logic [QUOT_W-1:0] QUOT_LIMIT = {1'b1, {(QUOT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] first_start_x;
        logic signed [COORD_W-1:0] first_start_y;
        logic signed [COORD_W-1:0] first_end_x;
        logic signed [COORD_W-1:0] first_end_y;
        logic signed [COORD_W-1:0] second_start_x;
        logic signed [COORD_W-1:0] second_start_y;
        logic signed [COORD_W-1:0] second_start_z;
        logic signed [COORD_W-1:0] second_end_x;
        logic signed [COORD_W-1:0] second_end_y;
        logic signed [COORD_W-1:0] second_end_z;
    } t_seg_in;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] cross_x;
        logic signed [COORD_W-1:0] cross_y;
        logic signed [COORD_W-1:0] cross_z;
    } t_seg_out;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic                                hit;
        logic [NUM_W-1:0]                    num_mag;
        logic                                num_neg;
        logic [NUM_W-1:0]                    den_mag;
        logic                                den_neg;
        logic [LANES-1:0][DIFF_W-1:0]        dir;
        logic [LANES-1:0][COORD_W-1:0]       base;
    } t_mid;

endpackage
`default_nettype wire

/* rtl/core/spi_front.sv */
// Front part: differences, cross products, side tests, numerator and divisor.
`default_nettype none
module spi_front
    import spi_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_vld,
    input  wire t_seg_in i_item,
    output logic         o_ready,
    input  wire logic    i_mid_full,
    output logic         o_mid_vld,
    output t_mid         o_mid
);

    logic r_v1, r_v2, r_v3;
    logic en;

    // Stage one registers: coordinate differences.
    logic signed [DIFF_W-1:0] r_v1x, r_v1y, r_v1xp, r_v2x, r_v2y;
    logic signed [DIFF_W-1:0] r_cyay, r_cxax, r_dyay, r_dxax, r_bycy, r_bxcx, r_dzcz;
    logic [LANES-1:0][COORD_W-1:0] r_base1, r_base2;
    logic [LANES-1:0][DIFF_W-1:0]  r_dir2;
    logic signed [DIFF_W-1:0] n_v1x;

    // Stage two registers: products.
    logic signed [PROD_W-1:0] r_ps1a, r_ps1b, r_ps2a, r_ps2b, r_pt1a, r_pt1b;
    logic signed [PROD_W-1:0] r_pt2a, r_pt2b, r_pna, r_pnb, r_pda, r_pdb;
    logic signed [DIFF_W-1:0] r_v1xp2;
    logic signed [DIFF_W-1:0] aycy, axcx;

    // Stage three combinational values.
    logic signed [WIDE_W-1:0] s1, s2, t1, t2, num, den, den_fix;
    logic same_a, same_b;
    t_mid r_mid;

    // The pipeline holds only when its last stage cannot drain.
    assign en        = !(r_v3 && i_mid_full);
    assign o_ready   = en;
    assign o_mid_vld = r_v3;
    assign o_mid     = r_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Differences of the coordinates, each one bit wider than its operands.
    assign n_v1x = DIFF_W'(i_item.first_end_x) - DIFF_W'(i_item.first_start_x);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v1x  <= n_v1x;
            r_v1xp <= (n_v1x == '0) ? DIFF_W'(1) : n_v1x;
            r_v1y  <= DIFF_W'(i_item.first_end_y) - DIFF_W'(i_item.first_start_y);
            r_v2x  <= DIFF_W'(i_item.second_end_x) - DIFF_W'(i_item.second_start_x);
            r_v2y  <= DIFF_W'(i_item.second_end_y) - DIFF_W'(i_item.second_start_y);
            r_dzcz <= DIFF_W'(i_item.second_end_z) - DIFF_W'(i_item.second_start_z);
            r_cyay <= DIFF_W'(i_item.second_start_y) - DIFF_W'(i_item.first_start_y);
            r_cxax <= DIFF_W'(i_item.second_start_x) - DIFF_W'(i_item.first_start_x);
            r_dyay <= DIFF_W'(i_item.second_end_y) - DIFF_W'(i_item.first_start_y);
            r_dxax <= DIFF_W'(i_item.second_end_x) - DIFF_W'(i_item.first_start_x);
            r_bycy <= DIFF_W'(i_item.first_end_y) - DIFF_W'(i_item.second_start_y);
            r_bxcx <= DIFF_W'(i_item.first_end_x) - DIFF_W'(i_item.second_start_x);
            r_base1[0] <= i_item.second_start_x;
            r_base1[1] <= i_item.second_start_y;
            r_base1[2] <= i_item.second_start_z;
        end
    end

    assign aycy = -r_cyay;
    assign axcx = -r_cxax;

    // Twelve products of 33-bit operands, registered.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ps1a  <= r_cyay * r_v1x;
            r_ps1b  <= r_cxax * r_v1y;
            r_ps2a  <= r_dyay * r_v1x;
            r_ps2b  <= r_dxax * r_v1y;
            r_pt1a  <= aycy * r_v2x;
            r_pt1b  <= axcx * r_v2y;
            r_pt2a  <= r_bycy * r_v2x;
            r_pt2b  <= r_bxcx * r_v2y;
            r_pna   <= aycy * r_v1xp;
            r_pnb   <= r_cxax * r_v1y;
            r_pda   <= r_v2y * r_v1xp;
            r_pdb   <= r_v1y * r_v2x;
            r_v1xp2 <= r_v1xp;
            r_base2 <= r_base1;
            r_dir2[0] <= r_v2x;
            r_dir2[1] <= r_v2y;
            r_dir2[2] <= r_dzcz;
        end
    end

    // Side tests and the line solution terms.
    always_comb begin
        s1  = WIDE_W'(r_ps1a) - WIDE_W'(r_ps1b);
        s2  = WIDE_W'(r_ps2a) - WIDE_W'(r_ps2b);
        t1  = WIDE_W'(r_pt1a) - WIDE_W'(r_pt1b);
        t2  = WIDE_W'(r_pt2a) - WIDE_W'(r_pt2b);
        num = WIDE_W'(r_pna) + WIDE_W'(r_pnb);
        den = WIDE_W'(r_pda) - WIDE_W'(r_pdb);
        den_fix = (den == '0) ? WIDE_W'(r_v1xp2) : den;
        same_a = (s1 != '0) && (s2 != '0) && (s1[WIDE_W-1] == s2[WIDE_W-1]);
        same_b = (t1 != '0) && (t2 != '0) && (t1[WIDE_W-1] == t2[WIDE_W-1]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mid.hit     <= !(same_a || same_b);
            r_mid.num_neg <= num[WIDE_W-1];
            r_mid.num_mag <= num[WIDE_W-1] ? NUM_W'(-num) : NUM_W'(num);
            r_mid.den_neg <= den_fix[WIDE_W-1];
            r_mid.den_mag <= den_fix[WIDE_W-1] ? NUM_W'(-den_fix) : NUM_W'(den_fix);
            r_mid.dir     <= r_dir2;
            r_mid.base    <= r_base2;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/spi_fifo.sv */
// Short queue that decouples the front part from the back part.
`default_nettype none
`include "segment_pair_intersection_xy_defines.svh"
module spi_fifo
    import spi_pkg::*;
#(
    parameter int unsigned DEPTH = MID_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_mid i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_mid      o_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_mid             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SPI_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "fifo overfilled")
    `SPI_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + 1'b1, "count did not rise")
    `SPI_ASSERT_NEXT(a_count_down, i_clk, i_rst_n, do_pop && !do_push, r_count == $past(r_count) - 1'b1, "count did not fall")

endmodule
`default_nettype wire

/* rtl/core/spi_back.sv */
// Back part: scaled numerators, pipelined division and saturated placement.
`default_nettype none
module spi_back
    import spi_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_mid_vld,
    input  wire t_mid i_mid,
    output logic      o_mid_pop,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_seg_out  o_item
);

    localparam int unsigned STAGES = QUOT_W + 1;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [QUOT_W-1:0]  quot;
        logic [MUL_W-1:0]   prod;
        logic               sat;
        logic               neg;
        logic [COORD_W-1:0] base;
    } t_lane;

    logic en;
    logic r_out_vld;
    t_seg_out r_out;

    // Multiplier stages.
    logic r_b1_vld, r_b2_vld, r_b1_hit, r_b2_hit;
    logic [NUM_W-1:0] r_b1_den, r_b2_den;
    logic [LANES-1:0][SPLIT_W+DIR_W-1:0]         r_pl;
    logic [LANES-1:0][NUM_W-SPLIT_W+DIR_W-1:0]   r_ph;
    logic [LANES-1:0]                            r_b1_neg, r_b2_neg;
    logic [LANES-1:0][COORD_W-1:0]               r_b1_base, r_b2_base;
    logic [LANES-1:0][MUL_W-1:0]                 r_prod;
    logic [LANES-1:0][DIR_W-1:0]                 dir_mag;

    // Divider stages.
    logic             r_dv  [STAGES];
    logic             r_dh  [STAGES];
    logic [NUM_W-1:0] r_dd  [STAGES];
    t_lane            r_ln  [STAGES][LANES];

    logic [LANES-1:0][COORD_W-1:0] placed;

    assign en        = !r_out_vld || i_pop;
    assign o_mid_pop = en && i_mid_vld;
    assign o_empty   = !r_out_vld;
    assign o_item    = r_out;

    // Magnitudes of the direction components.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            dir_mag[l] = i_mid.dir[l][DIFF_W-1] ? DIR_W'(-$signed(i_mid.dir[l]))
                                                 : DIR_W'(i_mid.dir[l]);
        end
    end

    // Split products, then their sum.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_hit  <= i_mid.hit;
            r_b1_den  <= i_mid.den_mag;
            r_b1_base <= i_mid.base;
            for (int l = 0; l < LANES; l++) begin
                r_pl[l] <= (SPLIT_W+DIR_W)'(i_mid.num_mag[SPLIT_W-1:0]) *
                           (SPLIT_W+DIR_W)'(dir_mag[l]);
                r_ph[l] <= (NUM_W-SPLIT_W+DIR_W)'(i_mid.num_mag[NUM_W-1:SPLIT_W]) *
                           (NUM_W-SPLIT_W+DIR_W)'(dir_mag[l]);
                r_b1_neg[l] <= i_mid.num_neg ^ i_mid.dir[l][DIFF_W-1] ^ i_mid.den_neg;
            end
            r_b2_hit  <= r_b1_hit;
            r_b2_den  <= r_b1_den;
            r_b2_base <= r_b1_base;
            r_b2_neg  <= r_b1_neg;
            for (int l = 0; l < LANES; l++) begin
                r_prod[l] <= MUL_W'(r_pl[l]) + {r_ph[l], {SPLIT_W{1'b0}}};
            end
        end
    end

    // Divider entry: overflow check on the top bits and the first remainder.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dh[0] <= r_b2_hit;
            r_dd[0] <= r_b2_den;
            for (int l = 0; l < LANES; l++) begin
                r_ln[0][l].rem  <= REM_W'(r_prod[l][MUL_W-1:QUOT_W]);
                r_ln[0][l].sat  <= REM_W'(r_prod[l][MUL_W-1:QUOT_W]) >= REM_W'(r_b2_den);
                r_ln[0][l].quot <= '0;
                r_ln[0][l].prod <= r_prod[l];
                r_ln[0][l].neg  <= r_b2_neg[l];
                r_ln[0][l].base <= r_b2_base[l];
            end
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 1; s < STAGES; s++) begin : g_div
        localparam int unsigned BIT = QUOT_W - s;
        logic [LANES-1:0][REM_W-1:0] trial;
        t_lane [LANES-1:0]           n_ln;
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                trial[l] = {r_ln[s-1][l].rem[REM_W-2:0], r_ln[s-1][l].prod[BIT]};
                n_ln[l]  = r_ln[s-1][l];
                if (trial[l] >= REM_W'(r_dd[s-1])) begin
                    n_ln[l].rem       = trial[l] - REM_W'(r_dd[s-1]);
                    n_ln[l].quot[BIT] = 1'b1;
                end else begin
                    n_ln[l].rem = trial[l];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dh[s] <= r_dh[s-1];
                r_dd[s] <= r_dd[s-1];
                for (int l = 0; l < LANES; l++) begin
                    r_ln[s][l] <= n_ln[l];
                end
            end
        end
    end

    // Valid bits of the back pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            for (int s = 0; s < STAGES; s++) begin
                r_dv[s] <= 1'b0;
            end
        end else if (en) begin
            r_b1_vld <= o_mid_pop;
            r_b2_vld <= r_b1_vld;
            r_dv[0]  <= r_b2_vld;
            for (int s = 1; s < STAGES; s++) begin
                r_dv[s] <= r_dv[s-1];
            end
        end
    end

    // Quotient clamp, signed offset and saturation to 32 bits.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            logic [QUOT_W-1:0]      mag;
            logic signed [SUM_W-1:0] sum;
            mag = (r_ln[STAGES-1][l].sat || (r_ln[STAGES-1][l].quot > QUOT_LIMIT))
                  ? QUOT_LIMIT : r_ln[STAGES-1][l].quot;
            sum = SUM_W'($signed(r_ln[STAGES-1][l].base)) +
                  (r_ln[STAGES-1][l].neg ? -$signed(SUM_W'(mag)) : $signed(SUM_W'(mag)));
            if (sum > SUM_W'(signed'(32'sh7FFF_FFFF))) begin
                placed[l] = 32'h7FFF_FFFF;
            end else if (sum < SUM_W'(signed'(32'sh8000_0000))) begin
                placed[l] = 32'h8000_0000;
            end else begin
                placed[l] = sum[COORD_W-1:0];
            end
        end
    end

    // Output register: the oldest result waits here until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dv[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.hit     <= r_dh[STAGES-1];
            r_out.cross_x <= r_dh[STAGES-1] ? placed[0] : '0;
            r_out.cross_y <= r_dh[STAGES-1] ? placed[1] : '0;
            r_out.cross_z <= r_dh[STAGES-1] ? placed[2] : '0;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/segment_pair_intersection_xy.sv */
// Top level of the segment pair intersection block.
// Takes one pair of segments per clock while full is low and returns one
// result per pair, in order. On the path from the accepting edge to the
// result on the ports, the first of three front stages (differences, products,
// side tests with numerator and divisor) loads at the accepting edge itself,
// then come the short queue, two stages that scale the numerator by each
// direction component, a 36-stage divider (an overflow check, then one
// quotient bit per stage for each of X, Y and Z) and the output register.
// The back part holds all its stages while a result waits untaken; the queue
// then absorbs the front part's items before full rises.
`default_nettype none
module segment_pair_intersection_xy
    import spi_pkg::*;
#(
    parameter int unsigned MID_DEPTH = MID_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_seg_in  i_item,
    output logic          empty,
    input  wire logic     pop,
    output t_seg_out      o_item
);

    logic front_ready, mid_vld, mid_full, mid_empty, mid_pop;
    t_mid front_mid, queue_mid;

    assign full = !front_ready;

    // Front part.
    spi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (push),
        .i_item     (i_item),
        .o_ready    (front_ready),
        .i_mid_full (mid_full),
        .o_mid_vld  (mid_vld),
        .o_mid      (front_mid)
    );

    // Queue between the two parts.
    spi_fifo #(.DEPTH(MID_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_vld),
        .i_data  (front_mid),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_empty (mid_empty),
        .o_data  (queue_mid)
    );

    // Back part.
    spi_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mid_vld (!mid_empty),
        .i_mid     (queue_mid),
        .o_mid_pop (mid_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_item)
    );

endmodule
`default_nettype wire
